### design/gcs_pkg.sv
// shared constants and types for the grid count table
`timescale 1ns / 1ps

package gcs_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int COUNT_BITS = 16;

  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int COORD_W    = $clog2(MAX_SIDE);
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CELLS_W    = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int GSIDE_W    = 7;
  localparam int CAP_W      = 16;
  localparam int DIV_CNT_W  = $clog2(ADDR_W);

  localparam logic [GSIDE_W-1:0]   GSIDE_RESET = GSIDE_W'(64);
  localparam logic [CAP_W-1:0]     CAP_RESET   = CAP_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_WRAP  = 3'd2,
    CMD_FIRST = 3'd3,
    CMD_NEXT  = 3'd4
  } cmd_e;

endpackage

### design/gcs_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module gcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/grid_count_table_with_occupied_scan.sv
// top level: grid count table with occupied cell scan
`timescale 1ns / 1ps

// After reset the block sweeps zeros through all MAX_SIDE squared cells of the count
// store, one cell per cycle, before it raises in_ready_o; configuration writes are
// taken at any time. One command is worked on at a time. Read and write pass through
// the shared small multiplier (cells in use, then linear address), a dispatch step,
// the store read port and the output load; when the address lies past the cells in
// use the store read is skipped. Scans walk the store through its single read port at
// one cell per cycle, and the bit-serial divider turns the linear index of a found cell
// into column and row. A finished result sits in the output register, and the next
// command is accepted while it waits to be taken.
module grid_count_table_with_occupied_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gcs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gcs_pkg::CMD_W-1:0]      command_i,
  input  logic [gcs_pkg::COORD_W-1:0]    col_i,
  input  logic [gcs_pkg::COORD_W-1:0]    row_i,
  input  logic [gcs_pkg::COUNT_BITS-1:0] new_count_i,
  input  logic [gcs_pkg::ADDR_W-1:0]     start_cell_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gcs_pkg::COORD_W-1:0]    cell_col_o,
  output logic [gcs_pkg::COORD_W-1:0]    cell_row_o,
  output logic [gcs_pkg::COUNT_BITS-1:0] count_o,
  output logic                        found_o,
  output logic                        over_capacity_o
);

  import gcs_pkg::*;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_DISP = 9'b000010000,
    S_ACC  = 9'b000100000,
    S_SCAN = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e state_q;

  logic [GSIDE_W-1:0]    gside_q;
  logic [CAP_W-1:0]      cap_q;

  cmd_e                  cmd_q;
  logic [COORD_W-1:0]    col_q, row_q;
  logic [COUNT_BITS-1:0] nc_q;
  logic [ADDR_W-1:0]     start_q;

  logic [CELLS_W-1:0]    cells_q, addr_q;
  logic [CELLS_W-1:0]    p_q, end_q;
  logic [ADDR_W-1:0]     wrap_end_q;
  logic [ADDR_W-1:0]     chk_q;
  logic                  chk_vld_q;
  logic [ADDR_W-1:0]     clr_q;

  logic [ADDR_W-1:0]     dq_q;
  logic [SIDE_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;

  logic [COORD_W-1:0]    res_col_q, res_row_q;
  logic [COUNT_BITS-1:0] res_count_q;
  logic                  res_found_q, res_over_q;

  logic                  out_vld_q;
  logic [COORD_W-1:0]    out_col_q, out_row_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic                  out_found_q, out_over_q;

  logic [SIDE_W-1:0]     side;
  logic [SIDE_W-1:0]     mul_b;
  logic [2*SIDE_W-1:0]   mul_p;
  logic [CELLS_W-1:0]    addr_sum;
  logic                  inr;
  logic [ADDR_W-1:0]     wrap_start;

  logic [SIDE_W:0]       trial;
  logic                  div_ge;
  logic [SIDE_W-1:0]     rem_nx;
  logic [ADDR_W-1:0]     dq_nx;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  logic                  in_xfer, out_load;

  // side in use
  always_comb begin
    if (gside_q == '0) begin
      side = SIDE_W'(1);
    end else if (SIDE_W'(gside_q) > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(gside_q);
    end
  end

  // shared multiplier
  assign mul_b    = (state_q == S_MUL1) ? side : SIDE_W'(row_q);
  assign mul_p    = side * mul_b;
  assign addr_sum = mul_p[CELLS_W-1:0] + CELLS_W'(col_q);
  assign inr      = addr_q < cells_q;
  assign wrap_start = ({1'b0, start_q} >= cells_q) ? '0 : start_q;

  // bit-serial divider
  assign trial  = {rem_q, dq_q[ADDR_W-1]};
  assign div_ge = trial >= {1'b0, side};
  assign rem_nx = div_ge ? SIDE_W'(trial - {1'b0, side}) : trial[SIDE_W-1:0];
  assign dq_nx  = {dq_q[ADDR_W-2:0], div_ge};

  // store ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q[ADDR_W-1:0];
    ram_wdata = nc_q;
    ram_raddr = p_q[ADDR_W-1:0];
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_DISP: begin
        ram_raddr = addr_q[ADDR_W-1:0];
      end
      S_ACC: begin
        ram_we = (cmd_q == CMD_WRITE);
      end
      default: begin
      end
    endcase
  end

  gcs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FIN) && (!out_vld_q || out_ready_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gside_q <= GSIDE_RESET;
      cap_q   <= CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_SIDE: gside_q <= cfg_data_i[GSIDE_W-1:0];
        REG_CAPACITY:  cap_q   <= cfg_data_i[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      chk_vld_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          state_q <= S_DISP;
        end
        S_DISP: begin
          chk_vld_q <= 1'b0;
          case (cmd_q)
            CMD_READ, CMD_WRITE: begin
              state_q <= inr ? S_ACC : S_FIN;
            end
            CMD_WRAP, CMD_FIRST: begin
              state_q <= S_SCAN;
            end
            CMD_NEXT: begin
              state_q <= inr ? S_SCAN : S_FIN;
            end
            default: begin
              state_q <= S_FIN;
            end
          endcase
        end
        S_ACC: begin
          state_q <= S_FIN;
        end
        S_SCAN: begin
          if (chk_vld_q && ram_rdata != '0) begin
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end else if (p_q < end_q) begin
            chk_vld_q <= 1'b1;
          end else if (wrap_end_q != '0) begin
            chk_vld_q <= 1'b0;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(ADDR_W - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q   <= cmd_e'(command_i);
        col_q   <= col_i;
        row_q   <= row_i;
        nc_q    <= new_count_i;
        start_q <= start_cell_i;
      end
      S_MUL1: begin
        cells_q <= mul_p[CELLS_W-1:0];
      end
      S_MUL2: begin
        addr_q <= addr_sum;
      end
      S_DISP: begin
        res_col_q   <= (cmd_q inside {CMD_READ, CMD_WRITE}) ? col_q : '0;
        res_row_q   <= (cmd_q inside {CMD_READ, CMD_WRITE}) ? row_q : '0;
        res_count_q <= '0;
        res_found_q <= 1'b0;
        res_over_q  <= 1'b0;
        wrap_end_q  <= (cmd_q == CMD_WRAP) ? wrap_start : '0;
        end_q       <= cells_q;
        p_q         <= (cmd_q == CMD_WRAP) ? CELLS_W'(wrap_start) :
                       (cmd_q == CMD_NEXT) ? addr_q + CELLS_W'(1) : '0;
      end
      S_ACC: begin
        res_count_q <= ram_rdata;
        res_found_q <= 1'b1;
        res_over_q  <= (cmd_q == CMD_WRITE) && (CAP_W'(nc_q) > cap_q);
      end
      S_SCAN: begin
        if (chk_vld_q && ram_rdata != '0) begin
          res_count_q <= ram_rdata;
          res_found_q <= 1'b1;
          dq_q        <= chk_q;
          rem_q       <= '0;
        end else if (p_q < end_q) begin
          chk_q <= p_q[ADDR_W-1:0];
          p_q   <= p_q + CELLS_W'(1);
        end else if (wrap_end_q != '0) begin
          p_q        <= '0;
          end_q      <= CELLS_W'(wrap_end_q);
          wrap_end_q <= '0;
        end
      end
      S_DIV: begin
        dq_q  <= dq_nx;
        rem_q <= rem_nx;
        if (div_cnt_q == DIV_CNT_W'(ADDR_W - 1)) begin
          res_col_q <= rem_nx[COORD_W-1:0];
          res_row_q <= dq_nx[COORD_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q   <= res_col_q;
      out_row_q   <= res_row_q;
      out_count_q <= res_count_q;
      out_found_q <= res_found_q;
      out_over_q  <= res_over_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign cell_col_o      = out_col_q;
  assign cell_row_o      = out_row_q;
  assign count_o         = out_count_q;
  assign found_o         = out_found_q;
  assign over_capacity_o = out_over_q;

endmodule

### design/gcs_checker.sv
// port level checks for the grid count table, bound to the top level
`timescale 1ns / 1ps

module gcs_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [gcs_pkg::COORD_W-1:0]    cell_col_o,
  input  logic [gcs_pkg::COORD_W-1:0]    cell_row_o,
  input  logic [gcs_pkg::COUNT_BITS-1:0] count_o,
  input  logic                        found_o,
  input  logic                        over_capacity_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o) && $stable(found_o)
      && $stable(cell_col_o) && $stable(cell_row_o) && $stable(over_capacity_o))
    else $error("stalled result changed");

  // a miss carries no count and no flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> count_o == '0 && !over_capacity_o)
    else $error("miss with nonzero count or flag");

  // over capacity only on a write that hit the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_capacity_o |-> found_o)
    else $error("over capacity without a hit");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a transfer");

endmodule

bind grid_count_table_with_occupied_scan gcs_checker u_gcs_checker (.*);
